### rtl/gs_pkg.sv
`default_nettype none
package gs_pkg;

  localparam logic [1:0] REQ_MATRIX = 2'd0;
  localparam logic [1:0] REQ_GUESS  = 2'd1;
  localparam logic [1:0] REQ_START  = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SWEEPS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPS_SQUARED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SIZE = 2'd2;

  localparam logic [15:0] MAX_SWEEPS_RST  = 16'd10000;
  localparam logic [62:0] EPS_SQUARED_RST = 63'd281;
  localparam logic [4:0]  ACTIVE_SIZE_RST = 5'd16;

  localparam logic signed [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic signed [63:0] S64_MIN = {1'b1, 63'd0};

  typedef struct packed {
    logic [1:0]         req_type;
    logic [3:0]         row_index;
    logic [3:0]         col_index;
    logic signed [63:0] value;
  } req_t;

  typedef struct packed {
    logic [3:0]         elem_index;
    logic signed [63:0] elem_value;
    logic               last;
    logic               converged;
    logic               div_error;
    logic [15:0]        sweeps_used;
  } res_t;

  typedef struct packed {
    logic load_mat;
    logic load_vec;
    logic start_run;
    logic i_clr;
    logic i_inc;
    logic j_clr;
    logic j_inc;
    logic acc_clr;
    logic cap_diag;
    logic mul_row;
    logic acc_add;
    logic div_row;
    logic row_write;
    logic mul_sq;
    logic norm_clr;
    logic norm_add;
    logic sweep_inc;
    logic set_conv;
    logic total_clr;
    logic total_add;
    logic sum_check;
    logic div_out;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic j_last;
    logic i_last;
    logic j_eq_i;
    logic diag_zero;
    logic total_zero;
    logic norm_lt_eps;
    logic sweep_lt_max;
    logic max_zero;
    logic mul_done;
    logic div_done;
    logic out_busy;
  } status_t;

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    mag = v[63] ? (64'd0 - v) : v;
  endfunction

  function automatic logic signed [63:0] from_mag(input logic neg, input logic [63:0] m);
    if (!neg) from_mag = m[63] ? S64_MAX : m;
    else      from_mag = m[63] ? S64_MIN : (64'd0 - m);
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add = s[64] ? S64_MIN : S64_MAX;
    else                sat_add = s[63:0];
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) sat_sub = s[64] ? S64_MIN : S64_MAX;
    else                sat_sub = s[63:0];
  endfunction

endpackage
`default_nettype wire

### rtl/gs_if.sv
`default_nettype none
interface gs_req_if;
  logic          valid;
  logic          ready;
  gs_pkg::req_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gs_res_if;
  logic          valid;
  logic          ready;
  gs_pkg::res_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface gs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gs_pkg::CFG_IDX_W-1:0]  index;
  logic [63:0]                   data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/gauss_seidel_linear_solver.sv
`default_nettype none
// channel  role    contents
// req      sink    req_type, row_index, col_index, value
// res      source  elem_index, elem_value, last, converged, div_error, sweeps_used
// cfg      sink    index, data (always ready)
//
// load requests are taken back to back
// a start request holds req.ready low until the last element is loaded out;
// each row does one multiply per off-diagonal element (four-step multiplier),
// captures the diagonal, then a bit-serial divide unless the diagonal is zero,
// and a square; each output element is mostly a bit-serial divide by the sum
// a res stall holds the output register and parks the controller until it frees
// synchronous reset restores the config
module gauss_seidel_linear_solver #(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 48
) (
  input  wire logic clk,
  input  wire logic rst,
  gs_req_if.sink    req,
  gs_res_if.source  res,
  gs_cfg_if.sink    cfg
);
  import gs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign cfg.ready = 1'b1;
  assign cfg_we    = cfg.valid & cfg.ready;

  gs_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .req_valid(req.valid), .req_type(req.data.req_type), .req_ready(req.ready),
    .cmd(cmd), .status(status)
  );

  gs_datapath #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status), .req_data(req.data),
    .cfg_we(cfg_we), .cfg_index(cfg.index), .cfg_data(cfg.data),
    .res_valid(res.valid), .res_ready(res.ready), .res_data(res.data)
  );

  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready && req.data.req_type == REQ_START |=> !req.ready)
    else $error("request taken during a run");

  a_conv_sweeps: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.data.converged |-> res.data.sweeps_used != 16'd0)
    else $error("converged with no sweep");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.ready && res.data.last |=> !res.valid)
    else $error("result after last element");
endmodule
`default_nettype wire

### rtl/gs_mul.sv
`default_nettype none
module gs_mul #(
  parameter int FRAC_BITS = 48
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] a,
  input  wire logic signed [63:0] b,
  output logic                    done,
  output logic signed [63:0]      result
);
  import gs_pkg::*;

  logic [63:0]  ua, ub;
  logic         neg;
  logic [127:0] prod;
  logic [2:0]   step;
  logic         busy;
  logic [31:0]  pa, pb;
  logic [63:0]  pp;
  logic [127:0] partial;
  logic [127:0] shifted;

  // one 32x32 partial product per cycle
  always_comb begin
    pa = step[0] ? ua[63:32] : ua[31:0];
    pb = step[1] ? ub[63:32] : ub[31:0];
    pp = pa * pb;
    case (step[1:0])
      2'd0:    partial = {64'd0, pp};
      2'd3:    partial = {pp, 64'd0};
      default: partial = {32'd0, pp, 32'd0};
    endcase
    shifted = prod >> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        ua   <= mag(a);
        ub   <= mag(b);
        neg  <= a[63] ^ b[63];
        prod <= '0;
        step <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (!step[2]) begin
          prod <= prod + partial;
          step <= step + 3'd1;
        end else begin
          if (|shifted[127:64]) result <= neg ? S64_MIN : S64_MAX;
          else                  result <= from_mag(neg, shifted[63:0]);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/gs_div.sv
`default_nettype none
module gs_div #(
  parameter int FRAC_BITS = 48
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [63:0] num,
  input  wire logic signed [63:0] den,
  output logic                    done,
  output logic signed [63:0]      result
);
  import gs_pkg::*;

  logic [127:0] dvd;
  logic [63:0]  ud;
  logic [63:0]  rem;
  logic [127:0] quo;
  logic [7:0]   cnt;
  logic         neg;
  logic         busy;
  logic [64:0]  trial;
  logic [64:0]  diff;
  logic         fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial = {rem, dvd[127]};
    diff  = trial - {1'b0, ud};
    fits  = trial >= {1'b0, ud};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dvd  <= {64'd0, mag(num)} << FRAC_BITS;
        ud   <= mag(den);
        rem  <= '0;
        quo  <= '0;
        cnt  <= '0;
        neg  <= num[63] ^ den[63];
        busy <= 1'b1;
      end else if (busy) begin
        if (!cnt[7]) begin
          rem <= fits ? diff[63:0] : trial[63:0];
          quo <= {quo[126:0], fits};
          dvd <= {dvd[126:0], 1'b0};
          cnt <= cnt + 8'd1;
        end else begin
          if (|quo[127:64]) result <= neg ? S64_MIN : S64_MAX;
          else              result <= from_mag(neg, quo[63:0]);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end
endmodule
`default_nettype wire

### rtl/gs_datapath.sv
`default_nettype none
module gs_datapath #(
  parameter int MAX_SIZE  = 16,
  parameter int FRAC_BITS = 48
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire gs_pkg::cmd_t                  cmd,
  output gs_pkg::status_t                    status,
  input  wire gs_pkg::req_t                  req_data,
  input  wire logic                          cfg_we,
  input  wire logic [gs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [63:0]                   cfg_data,
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output gs_pkg::res_t                       res_data
);
  import gs_pkg::*;

  localparam int IW    = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int NW    = $clog2(MAX_SIZE + 1);
  localparam int DEPTH = MAX_SIZE * MAX_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam logic signed [63:0] ONE = 64'sd1 << FRAC_BITS;

  logic [15:0]        max_sweeps;
  logic [62:0]        eps_squared;
  logic [4:0]         active_size;
  logic [NW-1:0]      n;
  logic [IW-1:0]      i, j;
  logic signed [63:0] acc, diag, xold, dx, total;
  logic [63:0]        norm;
  logic [15:0]        sweep;
  logic               err, conv;
  logic signed [63:0] a_rd, x_rd;
  logic signed [63:0] mat [DEPTH];
  logic signed [63:0] vec [MAX_SIZE];

  logic [AW-1:0]      rd_addr, wr_addr;
  logic               row_ok, col_ok;
  logic               vec_we;
  logic [IW-1:0]      vec_wa;
  logic signed [63:0] vec_wd;
  logic [64:0]        norm_sum;

  logic               mul_start, div_start;
  logic signed [63:0] mul_a, mul_b, mul_q;
  logic signed [63:0] div_n, div_d, div_q;
  logic               mul_done, div_done;

  always_comb begin
    rd_addr  = AW'(i) * AW'(MAX_SIZE) + AW'(j);
    wr_addr  = AW'(IW'(req_data.row_index)) * AW'(MAX_SIZE) + AW'(IW'(req_data.col_index));
    row_ok   = 32'(req_data.row_index) < MAX_SIZE;
    col_ok   = 32'(req_data.col_index) < MAX_SIZE;
    vec_we   = (cmd.load_vec && row_ok) || (cmd.row_write && diag != 64'sd0);
    vec_wa   = cmd.load_vec ? IW'(req_data.row_index) : i;
    vec_wd   = cmd.load_vec ? req_data.value : div_q;
    norm_sum = {1'b0, norm} + {1'b0, mul_q};

    mul_start = cmd.mul_row | cmd.mul_sq;
    mul_a     = cmd.mul_sq ? dx : a_rd;
    mul_b     = cmd.mul_sq ? dx : x_rd;
    div_start = cmd.div_row | cmd.div_out;
    div_n     = cmd.div_out ? x_rd : sat_sub(ONE, acc);
    div_d     = cmd.div_out ? total : diag;

    status.j_last       = NW'(j) == n - NW'(1);
    status.i_last       = NW'(i) == n - NW'(1);
    status.j_eq_i       = i == j;
    status.diag_zero    = diag == 64'sd0;
    status.total_zero   = total == 64'sd0;
    status.norm_lt_eps  = norm < {1'b0, eps_squared};
    status.sweep_lt_max = sweep < max_sweeps;
    status.max_zero     = max_sweeps == 16'd0;
    status.mul_done     = mul_done;
    status.div_done     = div_done;
    status.out_busy     = res_valid;
  end

  // matrix and vector stores, registered reads
  always_ff @(posedge clk) begin
    if (cmd.load_mat && row_ok && col_ok) mat[wr_addr] <= req_data.value;
    a_rd <= mat[rd_addr];
    if (vec_we) vec[vec_wa] <= vec_wd;
    x_rd <= vec[j];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_sweeps  <= MAX_SWEEPS_RST;
      eps_squared <= EPS_SQUARED_RST;
      active_size <= ACTIVE_SIZE_RST;
      sweep       <= '0;
      err         <= 1'b0;
      conv        <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_SWEEPS:  max_sweeps  <= cfg_data[15:0];
          CFG_EPS_SQUARED: eps_squared <= cfg_data[62:0];
          CFG_ACTIVE_SIZE: active_size <= cfg_data[4:0];
          default: ;
        endcase
      end
      if (cmd.start_run) begin
        sweep <= '0;
        err   <= 1'b0;
        conv  <= 1'b0;
        if (active_size < 5'd2)                 n <= NW'(2);
        else if (32'(active_size) > MAX_SIZE)   n <= NW'(MAX_SIZE);
        else                                    n <= NW'(active_size);
      end
      if (cmd.sweep_inc) sweep <= sweep + 16'd1;
      if (cmd.set_conv)  conv  <= 1'b1;
      if ((cmd.row_write && status.diag_zero) || (cmd.sum_check && status.total_zero))
        err <= 1'b1;

      if (cmd.i_clr) i <= '0;
      if (cmd.i_inc) i <= i + IW'(1);
      if (cmd.j_clr) j <= '0;
      if (cmd.j_inc) j <= j + IW'(1);

      if (cmd.acc_clr)  acc <= '0;
      if (cmd.acc_add)  acc <= sat_add(acc, mul_q);
      if (cmd.cap_diag) begin
        diag <= a_rd;
        xold <= x_rd;
      end
      if (cmd.row_write) dx <= status.diag_zero ? 64'sd0 : sat_sub(div_q, xold);
      if (cmd.norm_clr)  norm <= '0;
      if (cmd.norm_add)  norm <= norm_sum[64] ? {64{1'b1}} : norm_sum[63:0];
      if (cmd.total_clr) total <= '0;
      if (cmd.total_add) total <= sat_add(total, x_rd);

      if (res_valid && res_ready) res_valid <= 1'b0;
      if (cmd.out_load) begin
        res_valid            <= 1'b1;
        res_data.elem_index  <= 4'(j);
        res_data.elem_value  <= status.total_zero ? 64'sd0 : div_q;
        res_data.last        <= status.j_last;
        res_data.converged   <= conv;
        res_data.div_error   <= err;
        res_data.sweeps_used <= sweep;
      end
    end
  end

  gs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b),
    .done(mul_done), .result(mul_q)
  );

  gs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_n), .den(div_d),
    .done(div_done), .result(div_q)
  );
endmodule
`default_nettype wire

### rtl/gs_ctrl.sv
`default_nettype none
module gs_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  input  wire logic [1:0]      req_type,
  output logic                 req_ready,
  output gs_pkg::cmd_t         cmd,
  input  wire gs_pkg::status_t status
);
  import gs_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_SWEEP_INIT, ST_ROW_INIT, ST_ROW_RD, ST_ROW_USE,
    ST_ROW_MUL, ST_ROW_DIV, ST_ROW_DIVW, ST_ROW_WR, ST_ROW_SQ, ST_ROW_SQW,
    ST_SWEEP_END, ST_SWEEP_CHK, ST_SUM_INIT, ST_SUM_RD, ST_SUM_ADD, ST_SUM_CHK,
    ST_OUT_RD, ST_OUT_USE, ST_OUT_DIVW, ST_OUT_PUT
  } state_t;

  state_t state, state_next;

  assign req_ready = state == ST_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req_type)
            REQ_MATRIX: cmd.load_mat = 1'b1;
            REQ_GUESS:  cmd.load_vec = 1'b1;
            REQ_START: begin
              cmd.start_run = 1'b1;
              state_next    = ST_START;
            end
            default: ;
          endcase
        end
      end
      ST_START:      state_next = status.max_zero ? ST_SUM_INIT : ST_SWEEP_INIT;
      ST_SWEEP_INIT: begin
        cmd.i_clr    = 1'b1;
        cmd.norm_clr = 1'b1;
        state_next   = ST_ROW_INIT;
      end
      ST_ROW_INIT: begin
        cmd.j_clr   = 1'b1;
        cmd.acc_clr = 1'b1;
        state_next  = ST_ROW_RD;
      end
      ST_ROW_RD:     state_next = ST_ROW_USE;
      ST_ROW_USE: begin
        if (status.j_eq_i) begin
          cmd.cap_diag = 1'b1;
          if (status.j_last) state_next = ST_ROW_DIV;
          else begin
            cmd.j_inc  = 1'b1;
            state_next = ST_ROW_RD;
          end
        end else begin
          cmd.mul_row = 1'b1;
          state_next  = ST_ROW_MUL;
        end
      end
      ST_ROW_MUL: begin
        if (status.mul_done) begin
          cmd.acc_add = 1'b1;
          if (status.j_last) state_next = ST_ROW_DIV;
          else begin
            cmd.j_inc  = 1'b1;
            state_next = ST_ROW_RD;
          end
        end
      end
      ST_ROW_DIV: begin
        if (status.diag_zero) state_next = ST_ROW_WR;
        else begin
          cmd.div_row = 1'b1;
          state_next  = ST_ROW_DIVW;
        end
      end
      ST_ROW_DIVW:   if (status.div_done) state_next = ST_ROW_WR;
      ST_ROW_WR: begin
        cmd.row_write = 1'b1;
        state_next    = ST_ROW_SQ;
      end
      ST_ROW_SQ: begin
        cmd.mul_sq = 1'b1;
        state_next = ST_ROW_SQW;
      end
      ST_ROW_SQW: begin
        if (status.mul_done) begin
          cmd.norm_add = 1'b1;
          if (status.i_last) state_next = ST_SWEEP_END;
          else begin
            cmd.i_inc  = 1'b1;
            state_next = ST_ROW_INIT;
          end
        end
      end
      ST_SWEEP_END: begin
        cmd.sweep_inc = 1'b1;
        state_next    = ST_SWEEP_CHK;
      end
      ST_SWEEP_CHK: begin
        if (status.norm_lt_eps) begin
          cmd.set_conv = 1'b1;
          state_next   = ST_SUM_INIT;
        end else if (status.sweep_lt_max) state_next = ST_SWEEP_INIT;
        else state_next = ST_SUM_INIT;
      end
      ST_SUM_INIT: begin
        cmd.j_clr     = 1'b1;
        cmd.total_clr = 1'b1;
        state_next    = ST_SUM_RD;
      end
      ST_SUM_RD:     state_next = ST_SUM_ADD;
      ST_SUM_ADD: begin
        cmd.total_add = 1'b1;
        if (status.j_last) state_next = ST_SUM_CHK;
        else begin
          cmd.j_inc  = 1'b1;
          state_next = ST_SUM_RD;
        end
      end
      ST_SUM_CHK: begin
        cmd.sum_check = 1'b1;
        cmd.j_clr     = 1'b1;
        state_next    = ST_OUT_RD;
      end
      ST_OUT_RD:     state_next = ST_OUT_USE;
      ST_OUT_USE: begin
        if (status.total_zero) state_next = ST_OUT_PUT;
        else begin
          cmd.div_out = 1'b1;
          state_next  = ST_OUT_DIVW;
        end
      end
      ST_OUT_DIVW:   if (status.div_done) state_next = ST_OUT_PUT;
      ST_OUT_PUT: begin
        if (!status.out_busy) begin
          cmd.out_load = 1'b1;
          if (status.j_last) state_next = ST_IDLE;
          else begin
            cmd.j_inc  = 1'b1;
            state_next = ST_OUT_RD;
          end
        end
      end
      default:       state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end
endmodule
`default_nettype wire

### test/gs_checker.sv
module gs_checker
  import gs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  gs_req_if    req,
  gs_res_if    res,
  gs_cfg_if    cfg,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NMAX = 16;
  localparam int FB   = 48;
  localparam logic signed [63:0] FX_ONE = 64'sd1 <<< FB;

  logic signed [63:0] coef [NMAX*NMAX];
  logic signed [63:0] xvec [NMAX];
  logic [15:0]        sweep_limit;
  logic [62:0]        tol_sq;
  logic [4:0]         size_reg;
  res_t               solution_q [$];

  function automatic logic [63:0] abs64(input logic signed [63:0] v);
    return v[63] ? 64'd0 - v : v;
  endfunction

  // magnitude back to signed, clipped at the 64-bit bounds
  function automatic logic signed [63:0] signed_clip(input logic neg, input logic [127:0] m);
    if (!neg) return (m > 128'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : m[63:0];
    if (m >= 128'h8000_0000_0000_0000) return S64_MIN;
    return -$signed(m[63:0]);
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
    logic [127:0] p;
    logic         neg;
    neg = a[63] ^ b[63];
    p = ({64'd0, abs64(a)} * {64'd0, abs64(b)}) >> FB;
    if (p[127:64] != 0) return neg ? S64_MIN : S64_MAX;
    return signed_clip(neg, p);
  endfunction

  function automatic logic signed [63:0] qdiv(input logic signed [63:0] num,
                                              input logic signed [63:0] den);
    logic [127:0] q;
    logic         neg;
    neg = num[63] ^ den[63];
    q = ({64'd0, abs64(num)} << FB) / {64'd0, abs64(den)};
    if (q[127:64] != 0) return neg ? S64_MIN : S64_MAX;
    return signed_clip(neg, q);
  endfunction

  function automatic logic signed [63:0] add_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  function automatic logic signed [63:0] sub_clip(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} - {b[63], b};
    if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
    return s[63:0];
  endfunction

  task automatic solve_and_queue();
    logic signed [63:0] prev [NMAX];
    logic signed [63:0] acc, diag, dx, total;
    logic [64:0]        norm;
    logic [15:0]        sweeps;
    logic               conv, bad;
    int                 n;
    res_t               r;
    n = (size_reg < 2) ? 2 : (size_reg > NMAX) ? NMAX : size_reg;
    sweeps = 0;
    conv = 1'b0;
    bad = 1'b0;
    while (sweeps < sweep_limit) begin
      prev = xvec;
      for (int i = 0; i < n; i++) begin
        acc = 0;
        diag = coef[i*NMAX+i];
        for (int j = 0; j < n; j++)
          if (j != i) acc = add_clip(acc, qmul(coef[i*NMAX+j], xvec[j]));
        if (diag == 0) bad = 1'b1;
        else xvec[i] = qdiv(sub_clip(FX_ONE, acc), diag);
      end
      sweeps++;
      norm = 0;
      for (int i = 0; i < n; i++) begin
        dx = sub_clip(xvec[i], prev[i]);
        norm = norm + {1'b0, qmul(dx, dx)};
        if (norm[64]) norm = {1'b0, {64{1'b1}}};
      end
      if (norm[63:0] < {1'b0, tol_sq}) begin
        conv = 1'b1;
        break;
      end
    end
    total = 0;
    for (int i = 0; i < n; i++) total = add_clip(total, xvec[i]);
    if (total == 0) bad = 1'b1;
    for (int i = 0; i < n; i++) begin
      r.elem_index  = i[3:0];
      r.elem_value  = (total == 0) ? 64'sd0 : qdiv(xvec[i], total);
      r.last        = (i == n - 1);
      r.converged   = conv;
      r.div_error   = bad;
      r.sweeps_used = sweeps;
      solution_q.push_back(r);
    end
  endtask

  task automatic cmp_field(input string fname, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", fname, want, got);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      sweep_limit = MAX_SWEEPS_RST;
      tol_sq      = EPS_SQUARED_RST;
      size_reg    = ACTIVE_SIZE_RST;
      solution_q.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (solution_q.size() == 0) begin
          $error("unexpected solution element, index %0d", res.data.elem_index);
          fails++;
        end else begin
          want = solution_q.pop_front();
          cmp_field("elem_index", want.elem_index, res.data.elem_index);
          cmp_field("elem_value", want.elem_value, res.data.elem_value);
          cmp_field("last", want.last, res.data.last);
          cmp_field("converged", want.converged, res.data.converged);
          cmp_field("div_error", want.div_error, res.data.div_error);
          cmp_field("sweeps_used", want.sweeps_used, res.data.sweeps_used);
        end
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_MAX_SWEEPS:  sweep_limit = cfg.data[15:0];
          CFG_EPS_SQUARED: tol_sq = cfg.data[62:0];
          CFG_ACTIVE_SIZE: size_reg = cfg.data[4:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        case (req.data.req_type)
          REQ_MATRIX: coef[req.data.row_index*NMAX+req.data.col_index] = req.data.value;
          REQ_GUESS:  xvec[req.data.row_index] = req.data.value;
          REQ_START:  solve_and_queue();
          default: ;
        endcase
      end
    end
    pending = solution_q.size();
  end

endmodule

### test/tb_gauss_seidel_linear_solver.sv
module tb_gauss_seidel_linear_solver;
  timeunit 1ns;
  timeprecision 1ps;
  import gs_pkg::*;

  localparam int IDLE_LIMIT = 400000;
  localparam int NUM_ITEMS  = 210;
  localparam int LONG_HOLD  = 30000;
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic signed [63:0] FX_ONE = 64'sd1 <<< 48;

  logic clk;
  logic rst;
  int   fails, pending, idle_cycles, sent_items;
  bit   no_idle, hold_long;

  gs_req_if req_ch ();
  gs_res_if res_ch ();
  gs_cfg_if cfg_ch ();

  gauss_seidel_linear_solver uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  gs_checker chk (
    .clk     (clk),
    .rst     (rst),
    .req     (req_ch),
    .res     (res_ch),
    .cfg     (cfg_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // small term of either sign, at most a quarter in magnitude
  function automatic logic signed [63:0] small_term();
    return $signed({$urandom, $urandom}) >>> 17;
  endfunction

  function automatic logic signed [63:0] dominant_entry(input int r, input int c, input int n);
    if (r == c) return (64'(n) <<< 48) + small_term();
    return small_term();
  endfunction

  function automatic int clamp_size(input logic [4:0] s);
    return (s < 2) ? 2 : (s > 16) ? 16 : s;
  endfunction

  task automatic send_req(input logic [1:0] kind, input logic [3:0] r, input logic [3:0] c,
                          input logic signed [63:0] v);
    int g;
    g = pick_gap();
    if (g > 0) begin
      req_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.data.req_type  <= kind;
    req_ch.data.row_index <= r;
    req_ch.data.col_index <= c;
    req_ch.data.value     <= v;
    do @(posedge clk); while (!req_ch.ready);
    if (kind != REQ_NONE) sent_items++;
  endtask

  task automatic wait_results();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    // a trailing load may still be in flight
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_regs(input logic [63:0] sweeps, input logic [63:0] eps,
                          input logic [63:0] size);
    write_reg(CFG_MAX_SWEEPS, sweeps);
    write_reg(CFG_EPS_SQUARED, eps);
    write_reg(CFG_ACTIVE_SIZE, size);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_system(input int n);
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) send_req(REQ_MATRIX, 4'(r), 4'(c), dominant_entry(r, c, n));
      send_req(REQ_GUESS, 4'(r), 4'd0, small_term());
    end
  endtask

  // receiver side
  initial begin
    int stall;
    stall = 0;
    forever begin
      if (hold_long) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_long = 1'b0;
      end else begin
        if (stall > 0) begin
          res_ch.ready <= 1'b0;
          stall--;
        end else if (!no_idle && $urandom_range(0, 99) < 25) begin
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 3);
          res_ch.ready <= 1'b0;
        end else begin
          res_ch.ready <= 1'b1;
        end
        @(posedge clk);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [4:0]  size;
    logic [15:0] sweeps;
    logic [63:0] eps;
    int          n, k;
    no_idle    = 1'b0;
    hold_long  = 1'b0;
    sent_items = 0;
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_MAX_SWEEPS;
    cfg_ch.data  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extreme entries on a two by two system, with a stray request type
    set_regs(64'd3, 64'd0, 64'd0);
    send_req(REQ_MATRIX, 0, 0, FX_ONE);
    send_req(REQ_MATRIX, 0, 1, S64_MIN);
    send_req(REQ_MATRIX, 1, 0, S64_MAX);
    send_req(REQ_MATRIX, 1, 1, FX_ONE <<< 1);
    send_req(REQ_MATRIX, 15, 15, 64'shAAAA_AAAA_AAAA_AAAA);
    send_req(REQ_GUESS, 15, 0, 64'sh5555_5555_5555_5555);
    send_req(REQ_GUESS, 0, 0, -FX_ONE);
    send_req(REQ_GUESS, 1, 0, 64'sh0000_1234_5678_9ABC);
    send_req(REQ_NONE, 15, 15, S64_MAX);
    send_req(REQ_START, 0, 0, 0);
    // zero on the diagonal
    send_req(REQ_MATRIX, 0, 0, 64'sd0);
    send_req(REQ_MATRIX, 0, 1, FX_ONE >>> 1);
    send_req(REQ_MATRIX, 1, 0, FX_ONE >>> 2);
    send_req(REQ_START, 0, 0, 0);
    wait_results();
    // no sweeps and a guess that sums to zero
    set_regs(64'd0, 64'd281, 64'd1);
    send_req(REQ_GUESS, 0, 0, FX_ONE);
    send_req(REQ_GUESS, 1, 0, -FX_ONE);
    send_req(REQ_START, 0, 0, 0);
    wait_results();
    // eight unknowns, widest limits, upper config bits set
    set_regs({64{1'b1}}, {64{1'b1}}, 64'hFFFF_FFFF_FFFF_FFE8);
    no_idle = 1'b1;
    load_system(8);
    no_idle = 1'b0;
    send_req(REQ_START, 0, 0, 0);
    send_req(REQ_START, 0, 0, 0);
    wait_results();

    k = 0;
    while (sent_items < NUM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        size = 5'($urandom_range(7, 8));
        sweeps = 16'($urandom_range(1, 2));
      end else begin
        size = 5'($urandom_range(0, 6));
        sweeps = 16'($urandom_range(0, 16));
      end
      case ($urandom_range(0, 3))
        0: eps = 64'd0;
        1: eps = 64'd281;
        2: eps = {$urandom, $urandom} >> 16;
        default: eps = {$urandom, $urandom} | 64'h7FFF_0000_0000_0000;
      endcase
      set_regs({16'($urandom_range(0, 65535)), 32'($urandom), sweeps}, eps,
               {$urandom, 27'($urandom), size});
      n = clamp_size(size);
      no_idle = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 6) == 0) begin
        // junk values, stray requests
        repeat ($urandom_range(3, 12)) begin
          case ($urandom_range(0, 3))
            0: send_req(REQ_MATRIX, 4'($urandom), 4'($urandom), {$urandom, $urandom});
            1: send_req(REQ_GUESS, 4'($urandom), 4'($urandom), {$urandom, $urandom});
            default: send_req(REQ_NONE, 4'($urandom), 4'($urandom), {$urandom, $urandom});
          endcase
        end
      end else begin
        repeat ($urandom_range(0, 8)) begin
          int r, c;
          r = $urandom_range(0, n - 1);
          c = ($urandom_range(0, 2) == 0) ? r : $urandom_range(0, n - 1);
          send_req(REQ_MATRIX, 4'(r), 4'(c), dominant_entry(r, c, n));
        end
        repeat ($urandom_range(0, n)) send_req(REQ_GUESS, 4'($urandom_range(0, n - 1)), 4'd0,
                                               small_term());
      end
      // once, stall the output so the start backs up the request side
      if (k == 2) hold_long = 1'b1;
      send_req(REQ_START, 4'($urandom), 4'($urandom), {$urandom, $urandom});
      if (k == 2 || $urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          int r;
          r = $urandom_range(0, n - 1);
          send_req(REQ_MATRIX, 4'(r), 4'(r), dominant_entry(r, r, n));
        end
        send_req(REQ_START, 0, 0, 0);
      end
      wait_results();
      k++;
    end

    no_idle = 1'b0;
    wait_results();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
